FILE: src/ahl_pkg.sv
// ahl_pkg: shared types, register indexes, mode codes and timing constants
// for the headlight light sensor controller; no dependencies
package ahl_pkg;

    localparam int LEVEL_W = 8;
    localparam int CNT_W   = 14;
    localparam int IDX_W   = 3;

    localparam int ON_WINDOW  = 236;
    localparam int OFF_WINDOW = 436;
    localparam int LOCK_HOLD  = 10001;

    localparam logic [CNT_W-1:0] ON_LAST   = CNT_W'(ON_WINDOW - 1);
    localparam logic [CNT_W-1:0] OFF_LAST  = CNT_W'(OFF_WINDOW - 1);
    localparam logic [CNT_W-1:0] LOCK_LAST = CNT_W'(LOCK_HOLD - 1);

    localparam logic [IDX_W-1:0] REG_PARK_ON     = 3'd0;
    localparam logic [IDX_W-1:0] REG_PARK_OFF    = 3'd1;
    localparam logic [IDX_W-1:0] REG_BEAM_ON     = 3'd2;
    localparam logic [IDX_W-1:0] REG_BEAM_OFF    = 3'd3;
    localparam logic [IDX_W-1:0] REG_PARK_ON_AB  = 3'd4;
    localparam logic [IDX_W-1:0] REG_BEAM_ON_AB  = 3'd5;
    localparam logic [IDX_W-1:0] REG_BEAM_OFF_AB = 3'd6;
    localparam logic [IDX_W-1:0] REG_PARK_OFF_AB = 3'd7;

    localparam logic [LEVEL_W-1:0] RST_PARK_ON     = 8'd150;
    localparam logic [LEVEL_W-1:0] RST_PARK_OFF    = 8'd48;
    localparam logic [LEVEL_W-1:0] RST_BEAM_ON     = 8'd200;
    localparam logic [LEVEL_W-1:0] RST_BEAM_OFF    = 8'd50;
    localparam logic [LEVEL_W-1:0] RST_PARK_ON_AB  = 8'd140;
    localparam logic [LEVEL_W-1:0] RST_BEAM_ON_AB  = 8'd190;
    localparam logic [LEVEL_W-1:0] RST_BEAM_OFF_AB = 8'd60;
    localparam logic [LEVEL_W-1:0] RST_PARK_OFF_AB = 8'd48;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_QUAL   = 3'd1,
        MODE_MANUAL = 3'd2,
        MODE_LOCK   = 3'd3,
        MODE_OFF    = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        QK_PARK_ON  = 2'd0,
        QK_BEAM_ON  = 2'd1,
        QK_BEAM_OFF = 2'd2,
        QK_PARK_OFF = 2'd3
    } qual_kind_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] park_on_level;
        logic [LEVEL_W-1:0] park_off_level;
        logic [LEVEL_W-1:0] beam_on_level;
        logic [LEVEL_W-1:0] beam_off_level;
        logic [LEVEL_W-1:0] park_on_abort;
        logic [LEVEL_W-1:0] beam_on_abort;
        logic [LEVEL_W-1:0] beam_off_abort;
        logic [LEVEL_W-1:0] park_off_abort;
    } cfg_regs_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] light_level;
        logic               ignition_on;
        logic               park_pressed;
        logic               lock_active;
    } sample_t;

    typedef struct packed {
        logic  park_lamp;
        logic  low_beam;
        mode_t mode;
    } result_t;

endpackage

FILE: src/ahl_if.sv
// ahl_if: valid/ready channel interfaces for sample items, result items and
// configuration writes; depends on ahl_pkg
interface ahl_sample_if;
    logic                          valid;
    logic                          ready;
    logic [ahl_pkg::LEVEL_W-1:0]   light_level;
    logic                          ignition_on;
    logic                          park_pressed;
    logic                          lock_active;

    modport source (output valid, light_level, ignition_on, park_pressed, lock_active,
                    input ready);
    modport sink (input valid, light_level, ignition_on, park_pressed, lock_active,
                  output ready);
endinterface

interface ahl_result_if;
    logic       valid;
    logic       ready;
    logic       park_lamp;
    logic       low_beam;
    logic [2:0] mode;

    modport source (output valid, park_lamp, low_beam, mode, input ready);
    modport sink (input valid, park_lamp, low_beam, mode, output ready);
endinterface

interface ahl_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ahl_pkg::IDX_W-1:0]     index;
    logic [ahl_pkg::LEVEL_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: src/ahl_cfg_regs.sv
// ahl_cfg_regs: the eight threshold registers with their reset values
// depends on ahl_pkg
module ahl_cfg_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [ahl_pkg::IDX_W-1:0]    wr_index,
    input  logic [ahl_pkg::LEVEL_W-1:0]  wr_data,
    output ahl_pkg::cfg_regs_t           cfg
);

    ahl_pkg::cfg_regs_t cfg_reg;
    ahl_pkg::cfg_regs_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                ahl_pkg::REG_PARK_ON:     cfg_next.park_on_level  = wr_data;
                ahl_pkg::REG_PARK_OFF:    cfg_next.park_off_level = wr_data;
                ahl_pkg::REG_BEAM_ON:     cfg_next.beam_on_level  = wr_data;
                ahl_pkg::REG_BEAM_OFF:    cfg_next.beam_off_level = wr_data;
                ahl_pkg::REG_PARK_ON_AB:  cfg_next.park_on_abort  = wr_data;
                ahl_pkg::REG_BEAM_ON_AB:  cfg_next.beam_on_abort  = wr_data;
                ahl_pkg::REG_BEAM_OFF_AB: cfg_next.beam_off_abort = wr_data;
                ahl_pkg::REG_PARK_OFF_AB: cfg_next.park_off_abort = wr_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.park_on_level  <= ahl_pkg::RST_PARK_ON;
            cfg_reg.park_off_level <= ahl_pkg::RST_PARK_OFF;
            cfg_reg.beam_on_level  <= ahl_pkg::RST_BEAM_ON;
            cfg_reg.beam_off_level <= ahl_pkg::RST_BEAM_OFF;
            cfg_reg.park_on_abort  <= ahl_pkg::RST_PARK_ON_AB;
            cfg_reg.beam_on_abort  <= ahl_pkg::RST_BEAM_ON_AB;
            cfg_reg.beam_off_abort <= ahl_pkg::RST_BEAM_OFF_AB;
            cfg_reg.park_off_abort <= ahl_pkg::RST_PARK_OFF_AB;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/ahl_ctrl.sv
// ahl_ctrl: controller state registers and the per-item update logic
// (button edge, manual, qualifiers, lock hold); depends on ahl_pkg
module ahl_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  ahl_pkg::sample_t    smp,
    input  ahl_pkg::cfg_regs_t  cfg,
    output ahl_pkg::result_t    res
);

    logic                         park_reg, park_next;
    logic                         beam_reg, beam_next;
    ahl_pkg::mode_t               mode_reg, mode_next;
    ahl_pkg::qual_kind_t          kind_reg, kind_next;
    logic [ahl_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                         btn_reg, btn_next;

    logic                         press;
    logic                         do_start;
    logic [2:0]                   start_from;
    logic                         abort_now;
    logic                         win_end;
    logic [ahl_pkg::LEVEL_W-1:0]  lvl;

    function automatic logic start_wanted(input logic [1:0] k,
                                          input logic [ahl_pkg::LEVEL_W-1:0] v,
                                          input logic p,
                                          input logic b,
                                          input ahl_pkg::cfg_regs_t c);
        logic hit;
        case (k)
            ahl_pkg::QK_PARK_ON:  hit = (v > c.park_on_level) && !p;
            ahl_pkg::QK_BEAM_ON:  hit = (v > c.beam_on_level) && !b;
            ahl_pkg::QK_BEAM_OFF: hit = (v < c.beam_off_level) && b;
            default:              hit = (v < c.park_off_level) && p;
        endcase
        return hit;
    endfunction

    always_comb
    begin
        park_next  = park_reg;
        beam_next  = beam_reg;
        mode_next  = mode_reg;
        kind_next  = kind_reg;
        cnt_next   = cnt_reg;
        btn_next   = smp.park_pressed;
        lvl        = smp.light_level;
        press      = smp.park_pressed && !btn_reg;
        do_start   = 1'b0;
        start_from = 3'd0;
        abort_now  = 1'b0;
        win_end    = 1'b0;

        if (press)
        begin
            beam_next = 1'b0;
            if (smp.ignition_on)
                mode_next = ahl_pkg::MODE_MANUAL;
        end

        if (smp.ignition_on)
        begin
            case (mode_next)
                ahl_pkg::MODE_MANUAL:
                begin
                    park_next = smp.park_pressed;
                end
                ahl_pkg::MODE_LOCK:
                begin
                    park_next = smp.park_pressed;
                    beam_next = 1'b0;
                    mode_next = ahl_pkg::MODE_IDLE;
                end
                ahl_pkg::MODE_QUAL:
                begin
                    case (kind_reg)
                        ahl_pkg::QK_PARK_ON:  abort_now = lvl < cfg.park_on_abort;
                        ahl_pkg::QK_BEAM_ON:  abort_now = lvl < cfg.beam_on_abort;
                        ahl_pkg::QK_BEAM_OFF: abort_now = lvl > cfg.beam_off_abort;
                        default:              abort_now = lvl > cfg.park_off_abort;
                    endcase
                    win_end = (kind_reg == ahl_pkg::QK_PARK_ON ||
                               kind_reg == ahl_pkg::QK_BEAM_ON) ?
                              (cnt_reg >= ahl_pkg::ON_LAST) :
                              (cnt_reg >= ahl_pkg::OFF_LAST);
                    start_from = {1'b0, kind_reg} + 3'd1;
                    if (abort_now)
                    begin
                        do_start = 1'b1;
                    end
                    else if (win_end)
                    begin
                        do_start = 1'b1;
                        case (kind_reg)
                            ahl_pkg::QK_PARK_ON:
                            begin
                                if (lvl > cfg.beam_on_level)
                                    beam_next = 1'b1;
                                if (lvl > cfg.park_on_level)
                                    park_next = 1'b1;
                            end
                            ahl_pkg::QK_BEAM_ON:
                            begin
                                if (lvl > cfg.beam_on_level)
                                    beam_next = 1'b1;
                            end
                            ahl_pkg::QK_BEAM_OFF:
                            begin
                                if (lvl < cfg.beam_off_level)
                                    beam_next = 1'b0;
                            end
                            default:
                            begin
                                if (lvl < cfg.park_off_level)
                                    park_next = 1'b0;
                            end
                        endcase
                    end
                    else
                    begin
                        cnt_next = cnt_reg + ahl_pkg::CNT_W'(1);
                    end
                end
                default:
                begin
                    do_start   = 1'b1;
                    start_from = 3'd0;
                end
            endcase

            // first start condition from start_from onward wins
            if (do_start)
            begin
                mode_next = ahl_pkg::MODE_IDLE;
                for (int k = 3; k >= 0; k--)
                begin
                    if (3'(k) >= start_from &&
                        start_wanted(2'(k), lvl, park_next, beam_next, cfg))
                    begin
                        mode_next = ahl_pkg::MODE_QUAL;
                        kind_next = ahl_pkg::qual_kind_t'(2'(k));
                        cnt_next  = '0;
                    end
                end
            end
        end
        else if (mode_next == ahl_pkg::MODE_LOCK)
        begin
            if (cnt_reg >= ahl_pkg::LOCK_LAST)
            begin
                park_next = smp.park_pressed;
                beam_next = 1'b0;
                mode_next = ahl_pkg::MODE_OFF;
            end
            else
            begin
                cnt_next = cnt_reg + ahl_pkg::CNT_W'(1);
            end
        end
        else
        begin
            if (smp.lock_active && lvl > cfg.park_on_level)
            begin
                park_next = 1'b1;
                beam_next = 1'b1;
                cnt_next  = '0;
                mode_next = ahl_pkg::MODE_LOCK;
            end
            else
            begin
                park_next = smp.park_pressed;
                if (!smp.park_pressed)
                    beam_next = 1'b0;
                mode_next = ahl_pkg::MODE_OFF;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            park_reg <= 1'b0;
            beam_reg <= 1'b0;
            mode_reg <= ahl_pkg::MODE_OFF;
            kind_reg <= ahl_pkg::QK_PARK_ON;
            cnt_reg  <= '0;
            btn_reg  <= 1'b0;
        end
        else if (step)
        begin
            park_reg <= park_next;
            beam_reg <= beam_next;
            mode_reg <= mode_next;
            kind_reg <= kind_next;
            cnt_reg  <= cnt_next;
            btn_reg  <= btn_next;
        end
    end

    assign res.park_lamp = park_next;
    assign res.low_beam  = beam_next;
    assign res.mode      = mode_next;

endmodule

FILE: src/auto_headlight_light_sensor_controller_unit.sv
// Automatic headlight controller: one light sample item in, one lamp/mode
// result item out per item. An item sits in the input register, is
// evaluated against the controller state in a single pass and lands in the
// output register; a new item is taken every
// cycle while the result side keeps up; throughput is set only by the
// output register draining. Threshold registers are written through the
// configuration channel, which is always ready. Depends on ahl_pkg, ahl_if,
// ahl_cfg_regs and ahl_ctrl.
module auto_headlight_light_sensor_controller_unit
(
    input  logic          clk,
    input  logic          rst_n,
    ahl_sample_if.sink    sample,
    ahl_result_if.source  result,
    ahl_cfg_if.sink       cfg
);

    logic                 in_vld_reg, in_vld_next;
    ahl_pkg::sample_t     in_data_reg;
    logic                 out_vld_reg, out_vld_next;
    ahl_pkg::result_t     out_data_reg;
    logic                 advance;
    logic                 take;
    ahl_pkg::cfg_regs_t   cfg_regs;
    ahl_pkg::result_t     res;

    assign advance      = in_vld_reg && (!out_vld_reg || result.ready);
    assign sample.ready = !in_vld_reg || advance;
    assign take         = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (take)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (advance)
            out_vld_next = 1'b1;
        else if (result.ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg.light_level  <= sample.light_level;
            in_data_reg.ignition_on  <= sample.ignition_on;
            in_data_reg.park_pressed <= sample.park_pressed;
            in_data_reg.lock_active  <= sample.lock_active;
        end
        if (advance)
            out_data_reg <= res;
    end

    ahl_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_regs)
    );

    ahl_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .smp   (in_data_reg),
        .cfg   (cfg_regs),
        .res   (res)
    );

    assign result.valid     = out_vld_reg;
    assign result.park_lamp = out_data_reg.park_lamp;
    assign result.low_beam  = out_data_reg.low_beam;
    assign result.mode      = out_data_reg.mode;

endmodule

FILE: src/ahl_checker.sv
// ahl_checker: port-level assertions on result items of the headlight
// controller, bound to the top level; depends on ahl_pkg
module ahl_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       res_valid,
    input  logic       res_ready,
    input  logic       park_lamp,
    input  logic       low_beam,
    input  logic [2:0] mode
);

    // stalled result item holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(park_lamp) &&
        $stable(low_beam) && $stable(mode))
        else $error("result item changed while stalled");

    // manual mode is entered by a press, which always drops the low beam
    a_manual_no_beam: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && mode == ahl_pkg::MODE_MANUAL |-> !low_beam)
        else $error("low beam on in manual mode");

    // lock hold keeps parking lamps lit
    a_lock_park: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && mode == ahl_pkg::MODE_LOCK |-> park_lamp)
        else $error("parking lamp off during lock hold");

    // ignition-off idle never shows low beam alone
    a_off_beam: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && mode == ahl_pkg::MODE_OFF |-> park_lamp || !low_beam)
        else $error("low beam without parking lamp in ignition-off idle");

endmodule

bind auto_headlight_light_sensor_controller_unit ahl_checker u_ahl_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .park_lamp (result.park_lamp),
    .low_beam  (result.low_beam),
    .mode      (result.mode)
);

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for the headlight light sensor controller unit;
// a lamp model predicts every result item while both channels idle and stall at random
// depends on ahl_pkg, ahl_if and auto_headlight_light_sensor_controller_unit
module testbench;
    import ahl_pkg::*;

    logic clk;
    logic rst_n;

    ahl_sample_if samples ();
    ahl_result_if results ();
    ahl_cfg_if    cfg_wr ();

    auto_headlight_light_sensor_controller_unit u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (samples),
        .result (results),
        .cfg    (cfg_wr)
    );

    // lamp model state
    logic               park_q;
    logic               beam_q;
    mode_t              mode_q;
    qual_kind_t         kind_q;
    logic [CNT_W-1:0]   ticks_q;
    logic               btn_q;
    logic [LEVEL_W-1:0] thr [8];

    sample_t pending_samples [$];
    result_t expected_lamps [$];
    result_t lamps_due;
    int      queued_total = 0;
    int      errors = 0;

    int burst_left = 0;
    int idle_left = 0;
    bit offering;

    int stall_kind = 0;
    int stall_left = 0;
    int holdoff_left = 0;
    int rx_cycles = 0;

    cfg_regs_t next_thr;

    always #5 clk = ~clk;

    function automatic bit start_wanted(qual_kind_t k, logic [LEVEL_W-1:0] v);
        case (k)
            QK_PARK_ON:  return v > thr[REG_PARK_ON] && !park_q;
            QK_BEAM_ON:  return v > thr[REG_BEAM_ON] && !beam_q;
            QK_BEAM_OFF: return v < thr[REG_BEAM_OFF] && beam_q;
            default:     return v < thr[REG_PARK_OFF] && park_q;
        endcase
    endfunction

    function automatic void try_start(int from, logic [LEVEL_W-1:0] v);
        mode_q = MODE_IDLE;
        for (int k = from; k <= int'(QK_PARK_OFF); k++)
        begin
            if (start_wanted(qual_kind_t'(k), v))
            begin
                mode_q = MODE_QUAL;
                kind_q = qual_kind_t'(k);
                ticks_q = '0;
                return;
            end
        end
    endfunction

    function automatic void button_rule(logic pressed);
        if (!pressed)
        begin
            park_q = 1'b0;
            beam_q = 1'b0;
        end
        else
            park_q = 1'b1;
    endfunction

    function automatic void qualify(logic [LEVEL_W-1:0] v);
        bit abort_now;
        int window;
        window = (kind_q == QK_PARK_ON || kind_q == QK_BEAM_ON) ? ON_WINDOW : OFF_WINDOW;
        case (kind_q)
            QK_PARK_ON:  abort_now = v < thr[REG_PARK_ON_AB];
            QK_BEAM_ON:  abort_now = v < thr[REG_BEAM_ON_AB];
            QK_BEAM_OFF: abort_now = v > thr[REG_BEAM_OFF_AB];
            default:     abort_now = v > thr[REG_PARK_OFF_AB];
        endcase
        if (abort_now)
        begin
            try_start(int'(kind_q) + 1, v);
            return;
        end
        if (int'(ticks_q) + 1 >= window)
        begin
            case (kind_q)
                QK_PARK_ON:
                begin
                    if (v > thr[REG_BEAM_ON])
                        beam_q = 1'b1;
                    if (v > thr[REG_PARK_ON])
                        park_q = 1'b1;
                end
                QK_BEAM_ON:
                    if (v > thr[REG_BEAM_ON])
                        beam_q = 1'b1;
                QK_BEAM_OFF:
                    if (v < thr[REG_BEAM_OFF])
                        beam_q = 1'b0;
                default:
                    if (v < thr[REG_PARK_OFF])
                        park_q = 1'b0;
            endcase
            try_start(int'(kind_q) + 1, v);
            return;
        end
        ticks_q = ticks_q + CNT_W'(1);
    endfunction

    function automatic result_t predict_lamps(sample_t s);
        result_t r;
        if (s.park_pressed && !btn_q)
        begin
            beam_q = 1'b0;
            if (s.ignition_on)
                mode_q = MODE_MANUAL;
        end
        btn_q = s.park_pressed;
        if (s.ignition_on)
        begin
            case (mode_q)
                MODE_MANUAL: park_q = s.park_pressed;
                MODE_LOCK:
                begin
                    park_q = 1'b0;
                    beam_q = 1'b0;
                    button_rule(s.park_pressed);
                    mode_q = MODE_IDLE;
                end
                MODE_QUAL: qualify(s.light_level);
                default:   try_start(int'(QK_PARK_ON), s.light_level);
            endcase
        end
        else if (mode_q == MODE_LOCK)
        begin
            if (int'(ticks_q) + 1 >= LOCK_HOLD)
            begin
                park_q = 1'b0;
                beam_q = 1'b0;
                button_rule(s.park_pressed);
                mode_q = MODE_OFF;
            end
            else
                ticks_q = ticks_q + CNT_W'(1);
        end
        else if (s.lock_active && s.light_level > thr[REG_PARK_ON])
        begin
            park_q = 1'b1;
            beam_q = 1'b1;
            ticks_q = '0;
            mode_q = MODE_LOCK;
        end
        else
        begin
            button_rule(s.park_pressed);
            mode_q = MODE_OFF;
        end
        r.park_lamp = park_q;
        r.low_beam = beam_q;
        r.mode = mode_q;
        return r;
    endfunction

    function automatic void queue_sample(int lvl, int ign, int btn, int lock);
        sample_t s;
        s.light_level = lvl[LEVEL_W-1:0];
        s.ignition_on = ign[0];
        s.park_pressed = btn[0];
        s.lock_active = lock[0];
        pending_samples.push_back(s);
        queued_total++;
    endfunction

    // steady ignition-on run, optionally with one stray sample
    function automatic void queue_run(int len, int lo, int hi, bit spoil);
        int bad_at;
        bad_at = spoil ? int'($urandom_range(0, len - 1)) : -1;
        for (int i = 0; i < len; i++)
            queue_sample(i == bad_at ? $urandom_range(0, 255) : $urandom_range(hi, lo),
                         1, 0, $urandom_range(0, 1));
    endfunction

    function automatic void queue_lock_hold(int hold);
        int lvl;
        lvl = (thr[REG_PARK_ON] == 8'hFF) ? 255
              : int'($urandom_range(int'(thr[REG_PARK_ON]) + 1, 255));
        queue_sample($urandom_range(0, 255), 0, 0, 0);
        queue_sample(lvl, 0, $urandom_range(0, 1), 1);
        repeat (hold)
            queue_sample($urandom_range(0, 255), 0, $urandom_range(0, 1), $urandom_range(0, 1));
    endfunction

    function automatic void queue_random_mix(int n);
        int stop_at;
        int pick;
        int lo;
        int hi;
        int len;
        bit btn;
        stop_at = queued_total + n;
        while (queued_total < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                lo = (thr[REG_PARK_ON_AB] > thr[REG_BEAM_ON_AB]) ? int'(thr[REG_PARK_ON_AB])
                     : int'(thr[REG_BEAM_ON_AB]);
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(ON_WINDOW, 2 * ON_WINDOW + 8)
                      : $urandom_range(8, ON_WINDOW + 8);
                if (len > stop_at - queued_total)
                    len = stop_at - queued_total;
                queue_run(len, lo, 255, $urandom_range(0, 1) == 0);
            end
            else if (pick < 45)
            begin
                hi = (thr[REG_BEAM_OFF_AB] < thr[REG_PARK_OFF_AB]) ? int'(thr[REG_BEAM_OFF_AB])
                     : int'(thr[REG_PARK_OFF_AB]);
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(OFF_WINDOW, 2 * OFF_WINDOW + 8)
                      : $urandom_range(8, OFF_WINDOW + 8);
                if (len > stop_at - queued_total)
                    len = stop_at - queued_total;
                queue_run(len, 0, hi, $urandom_range(0, 1) == 0);
            end
            else if (pick < 60)
            begin
                queue_lock_hold($urandom_range(1, 40));
                queue_sample($urandom_range(0, 255), 1, $urandom_range(0, 1),
                             $urandom_range(0, 1));
            end
            else if (pick < 75)
            begin
                btn = 1'b0;
                repeat ($urandom_range(4, 30))
                begin
                    if ($urandom_range(0, 3) == 0)
                        btn = ~btn;
                    queue_sample($urandom_range(0, 255), 1, int'(btn), $urandom_range(0, 1));
                end
                repeat ($urandom_range(1, 3))
                    queue_sample($urandom_range(0, 255), 0, $urandom_range(0, 1),
                                 $urandom_range(0, 1));
            end
            else
            begin
                repeat ($urandom_range(5, 40))
                    queue_sample($urandom_range(0, 255), $urandom_range(0, 3) != 0,
                                 $urandom_range(0, 7) == 0, $urandom_range(0, 1));
            end
        end
    endfunction

    task automatic wait_drained();
        while (pending_samples.size() != 0 || expected_lamps.size() != 0 || samples.valid)
            @(posedge clk);
    endtask

    // call in a rising-edge step; leaves valid high for a following write
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [LEVEL_W-1:0] val);
        cfg_wr.index <= idx;
        cfg_wr.data <= val;
        cfg_wr.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_wr.ready);
        thr[idx] = val;
    endtask

    task automatic apply_thresholds(cfg_regs_t c);
        write_reg(REG_PARK_ON, c.park_on_level);
        write_reg(REG_PARK_OFF, c.park_off_level);
        write_reg(REG_BEAM_ON, c.beam_on_level);
        write_reg(REG_BEAM_OFF, c.beam_off_level);
        write_reg(REG_PARK_ON_AB, c.park_on_abort);
        write_reg(REG_BEAM_ON_AB, c.beam_on_abort);
        write_reg(REG_BEAM_OFF_AB, c.beam_off_abort);
        write_reg(REG_PARK_OFF_AB, c.park_off_abort);
        cfg_wr.valid <= 1'b0;
    endtask

    // sample driver: bursts of items with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            samples.valid <= 1'b0;
        else
        begin
            if (samples.valid && samples.ready)
            begin
                expected_lamps.push_back(predict_lamps(pending_samples.pop_front()));
                offering = 1'b0;
            end
            else
                offering = samples.valid;
            if (!offering)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    samples.valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    samples.light_level <= pending_samples[0].light_level;
                    samples.ignition_on <= pending_samples[0].ignition_on;
                    samples.park_pressed <= pending_samples[0].park_pressed;
                    samples.lock_active <= pending_samples[0].lock_active;
                    samples.valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 48);
                        idle_left = ($urandom_range(0, 2) == 0) ? 0
                                    : ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12)
                                    : $urandom_range(1, 4);
                    end
                end
                else
                    samples.valid <= 1'b0;
            end
        end
    end

    // result ready: stall patterns plus a periodic long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            results.ready <= 1'b0;
        else
        begin
            rx_cycles++;
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                results.ready <= 1'b0;
            end
            else if (rx_cycles % 2000 == 500)
            begin
                holdoff_left = 400;
                results.ready <= 1'b0;
            end
            else
            begin
                if (stall_left == 0)
                begin
                    stall_kind = $urandom_range(0, 3);
                    stall_left = $urandom_range(8, 80);
                end
                stall_left--;
                case (stall_kind)
                    0:       results.ready <= 1'b1;
                    1:       results.ready <= 1'($urandom_range(0, 1));
                    2:       results.ready <= (rx_cycles % 4) != 0;
                    default: results.ready <= $urandom_range(0, 3) == 0;
                endcase
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && results.valid && results.ready)
        begin
            if (expected_lamps.size() == 0)
            begin
                if (errors < 100)
                    $display("%0t: unexpected result park %0b beam %0b mode %0d", $time,
                             results.park_lamp, results.low_beam, results.mode);
                errors++;
            end
            else
            begin
                lamps_due = expected_lamps.pop_front();
                if ({results.park_lamp, results.low_beam, results.mode} !== lamps_due)
                begin
                    if (errors < 100)
                        $display({"%0t: expected park %0b beam %0b mode %0d, ",
                                  "got park %0b beam %0b mode %0d"},
                                 $time, lamps_due.park_lamp, lamps_due.low_beam, lamps_due.mode,
                                 results.park_lamp, results.low_beam, results.mode);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        samples.valid = 1'b0;
        samples.light_level = '0;
        samples.ignition_on = 1'b0;
        samples.park_pressed = 1'b0;
        samples.lock_active = 1'b0;
        results.ready = 1'b0;
        cfg_wr.valid = 1'b0;
        cfg_wr.index = '0;
        cfg_wr.data = '0;

        park_q = 1'b0;
        beam_q = 1'b0;
        mode_q = MODE_OFF;
        kind_q = QK_PARK_ON;
        ticks_q = '0;
        btn_q = 1'b0;
        thr[REG_PARK_ON] = RST_PARK_ON;
        thr[REG_PARK_OFF] = RST_PARK_OFF;
        thr[REG_BEAM_ON] = RST_BEAM_ON;
        thr[REG_BEAM_OFF] = RST_BEAM_OFF;
        thr[REG_PARK_ON_AB] = RST_PARK_ON_AB;
        thr[REG_BEAM_ON_AB] = RST_BEAM_ON_AB;
        thr[REG_BEAM_OFF_AB] = RST_BEAM_OFF_AB;
        thr[REG_PARK_OFF_AB] = RST_PARK_OFF_AB;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: button rule, lock hold entry and exit, aborts, manual mode, boundaries
        queue_sample(0, 0, 0, 0);
        queue_sample(0, 0, 1, 0);
        queue_sample(0, 0, 0, 0);
        queue_sample(255, 0, 0, 1);
        queue_sample(0, 0, 1, 1);
        queue_sample(0, 1, 1, 0);
        queue_sample(0, 1, 0, 0);
        queue_sample(255, 1, 0, 0);
        queue_sample(151, 1, 0, 0);
        queue_sample(255, 1, 0, 0);
        queue_sample(100, 1, 0, 0);
        queue_sample(0, 0, 0, 0);
        queue_sample(150, 1, 0, 0);
        queue_sample(151, 1, 0, 0);
        queue_sample(140, 1, 0, 0);
        queue_sample(139, 1, 0, 0);
        queue_sample(255, 1, 1, 0);
        queue_sample(255, 1, 1, 0);
        queue_sample(0, 1, 0, 0);
        queue_sample(0, 1, 1, 0);
        queue_sample(0, 0, 0, 1);
        queue_sample(150, 0, 0, 1);
        queue_sample(151, 0, 1, 1);
        queue_sample(255, 1, 0, 0);
        queue_sample(0, 0, 0, 0);

        // full bright then full dark pass, then a lock hold
        queue_run(ON_WINDOW + 4, int'(thr[REG_BEAM_ON]) + 1, 255, 1'b0);
        queue_run(2 * OFF_WINDOW + 4, 0, int'(thr[REG_PARK_OFF]) - 1, 1'b0);
        queue_lock_hold(40);
        queue_random_mix(150);
        wait_drained();

        next_thr = {$urandom(), $urandom()};
        apply_thresholds(next_thr);
        queue_random_mix(220);
        wait_drained();

        apply_thresholds('0);
        queue_random_mix(90);
        wait_drained();

        apply_thresholds('1);
        queue_random_mix(90);
        wait_drained();

        next_thr = '{park_on_level: 8'd0, park_off_level: 8'd255, beam_on_level: 8'd0,
                     beam_off_level: 8'd255, park_on_abort: 8'd0, beam_on_abort: 8'd0,
                     beam_off_abort: 8'd255, park_off_abort: 8'd255};
        apply_thresholds(next_thr);
        queue_random_mix(180);
        wait_drained();

        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("auto_headlight_light_sensor_controller_unit: match");
        else
            $display("auto_headlight_light_sensor_controller_unit: mismatch");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("auto_headlight_light_sensor_controller_unit: mismatch");
        $finish;
    end

endmodule
